// ----- rtl/mmcs_pkg.sv -----
// ----------------------------------------------------------------------------
// mmcs_pkg: shared types and constants of the min-max contrast stretch
// Sample width, datapath widths, the map request record, queue status and
// the state type of the mapping engine.
// ----------------------------------------------------------------------------
package mmcs_pkg;

    // Width of a source sample, two's complement
    localparam int SAMPLE_BITS = 16;

    // Output pixel width and the saturation limit
    localparam int PIX_W   = 8;
    localparam int PIX_MAX = (1 << PIX_W) - 1;

    // sample - frame_min, signed
    localparam int DIFF_W = SAMPLE_BITS + 1;
    // frame_max - frame_min, never negative
    localparam int DEN_W  = SAMPLE_BITS;
    // out_high - out_low, signed
    localparam int SPAN_W = PIX_W + 1;
    // Product of difference and span, and its magnitude for the divider
    localparam int NUM_W  = DIFF_W + SPAN_W;
    localparam int MAG_W  = NUM_W;
    localparam int CNT_W  = $clog2(MAG_W);

    // Request queue between the front and the back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    // Operation codes of an input item
    localparam logic OP_MEASURE = 1'b0;
    localparam logic OP_MAP     = 1'b1;

    // Configuration register indexes
    localparam int   REG_IDX_W    = 1;
    localparam logic REG_OUT_LOW  = 1'b0;
    localparam logic REG_OUT_HIGH = 1'b1;

    // Everything the back needs to map one sample
    typedef struct packed {
        logic signed [DIFF_W-1:0] diff;
        logic        [DEN_W-1:0]  den;
        logic signed [SPAN_W-1:0] span;
        logic        [PIX_W-1:0]  lo;
        logic                     flat;
    } map_req_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    // Mapping engine states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ABS,
        ST_DIV,
        ST_FIX,
        ST_RND,
        ST_DONE
    } back_state_t;

endpackage

// ----- rtl/min_max_contrast_stretch.sv -----
// ----------------------------------------------------------------------------
// min_max_contrast_stretch: two-pass min-max contrast stretch
// Measure requests gather frame extremes; map requests return stretched,
// rounded and saturated 8-bit pixels.
// ----------------------------------------------------------------------------
// Measure requests (op 0) are taken one per cycle while the queue has room
// and produce no result; last closes the frame and the next measure request
// opens a new one. Each map request (op 1) yields one pixel: a flat frame
// skips the divider; others pass the abs step, a bit-serial divider (one
// quotient bit a cycle), fix and round. A two-entry request queue lets
// intake run ahead of the divider; a filled output register waits for
// out_ready, and intake stalls once the queue fills. The user must write
// out_low and out_high through cfg_we/cfg_index/cfg_data only while idle.
module min_max_contrast_stretch (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic                                    op,
    input  logic signed [mmcs_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                                    last,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [mmcs_pkg::PIX_W-1:0]              pixel_out,
    output logic                                    flat,
    input  logic                                    cfg_we,
    input  logic [mmcs_pkg::REG_IDX_W-1:0]          cfg_index,
    input  logic [mmcs_pkg::PIX_W-1:0]              cfg_data
);
    import mmcs_pkg::*;

    q_stat_t   q_stat;
    logic      q_push;
    logic      q_pop;
    map_req_t  q_wdata;
    map_req_t  q_rdata;

    mmcs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .sample    (sample),
        .last      (last),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_wdata   (q_wdata)
    );

    mmcs_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .stat  (q_stat)
    );

    mmcs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .q_rdata   (q_rdata),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pixel_out (pixel_out),
        .flat      (flat)
    );

endmodule

// ----- rtl/mmcs_front.sv -----
// ----------------------------------------------------------------------------
// mmcs_front: request intake and frame statistics
// Accepts input requests, tracks the frame minimum and maximum on measure
// requests, holds the output range registers and queues map requests.
// ----------------------------------------------------------------------------
module mmcs_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 op,
    input  logic signed [mmcs_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                                 last,
    input  logic                                 cfg_we,
    input  logic [mmcs_pkg::REG_IDX_W-1:0]       cfg_index,
    input  logic [mmcs_pkg::PIX_W-1:0]           cfg_data,
    input  mmcs_pkg::q_stat_t                    q_stat,
    output logic                                 q_push,
    output mmcs_pkg::map_req_t                   q_wdata
);
    import mmcs_pkg::*;

    logic signed [SAMPLE_BITS-1:0] frame_min_reg;
    logic signed [SAMPLE_BITS-1:0] frame_max_reg;
    logic                          frame_open_reg;
    logic [PIX_W-1:0]              out_low_reg;
    logic [PIX_W-1:0]              out_high_reg;
    logic                          accept;
    logic signed [DIFF_W-1:0]      diff_full;
    logic signed [DIFF_W-1:0]      den_full;

    // Accept whenever the queue has room
    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;
    assign q_push   = accept && (op == OP_MAP);

    // Build the map request from the extremes seen so far
    assign diff_full = DIFF_W'(sample) - DIFF_W'(frame_min_reg);
    assign den_full  = DIFF_W'(frame_max_reg) - DIFF_W'(frame_min_reg);

    always_comb
    begin
        q_wdata.diff = diff_full;
        q_wdata.den  = den_full[DEN_W-1:0];
        q_wdata.span = $signed({1'b0, out_high_reg}) - $signed({1'b0, out_low_reg});
        q_wdata.lo   = out_low_reg;
        q_wdata.flat = (frame_max_reg == frame_min_reg);
    end

    // Track the frame extremes; the first sample of a frame loads both
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_min_reg  <= '0;
            frame_max_reg  <= '0;
            frame_open_reg <= 1'b0;
        end
        else if (accept && (op == OP_MEASURE))
        begin
            if (!frame_open_reg)
            begin
                frame_min_reg <= sample;
                frame_max_reg <= sample;
            end
            else
            begin
                if (sample < frame_min_reg)
                    frame_min_reg <= sample;
                if (sample > frame_max_reg)
                    frame_max_reg <= sample;
            end
            frame_open_reg <= !last;
        end
    end

    // Write the output range registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_low_reg  <= '0;
            out_high_reg <= PIX_W'(PIX_MAX);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_OUT_LOW:  out_low_reg  <= cfg_data;
                REG_OUT_HIGH: out_high_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // The measured range never inverts
    a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
        frame_min_reg <= frame_max_reg)
        else $error("frame minimum above frame maximum");

endmodule

// ----- rtl/mmcs_queue.sv -----
// ----------------------------------------------------------------------------
// mmcs_queue: map request queue
// Short register queue that decouples request intake from the mapping engine.
// ----------------------------------------------------------------------------
module mmcs_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  mmcs_pkg::map_req_t  wdata,
    input  logic                pop,
    output mmcs_pkg::map_req_t  rdata,
    output mmcs_pkg::q_stat_t   stat
);
    import mmcs_pkg::*;

    map_req_t             entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_PTR_W:0]     count_reg;

    assign rdata      = entry_reg[rd_ptr_reg];
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == (Q_PTR_W+1)'(Q_DEPTH));

    // Store pushed requests
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wdata;
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !stat.full)
        else $error("request pushed into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !stat.empty)
        else $error("request popped from empty queue");

endmodule

// ----- rtl/mmcs_back.sv -----
// ----------------------------------------------------------------------------
// mmcs_back: mapping engine
// Multiplies the offset by the output span, divides by the frame range one
// quotient bit a cycle, rounds half to even, saturates and presents results.
// ----------------------------------------------------------------------------
module mmcs_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  mmcs_pkg::q_stat_t         q_stat,
    input  mmcs_pkg::map_req_t        q_rdata,
    output logic                      q_pop,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [mmcs_pkg::PIX_W-1:0] pixel_out,
    output logic                      flat
);
    import mmcs_pkg::*;

    back_state_t              state_reg;
    back_state_t              state_next;
    map_req_t                 req_reg;
    logic signed [NUM_W-1:0]  num_reg;
    logic                     neg_reg;
    logic [MAG_W-1:0]         dq_reg;
    logic [DEN_W-1:0]         rem_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic signed [NUM_W-1:0]  q_reg;
    logic [DEN_W-1:0]         r_reg;
    logic [PIX_W-1:0]         res_pix;
    logic                     res_flat;
    logic                     out_valid_reg;
    logic [PIX_W-1:0]         pixel_out_reg;
    logic                     flat_reg;

    logic                     out_free;
    logic                     out_load;
    logic [DEN_W:0]           rem_sh;
    logic [DEN_W:0]           den_x;
    logic                     ge;
    logic [DEN_W:0]           trial;
    logic [DEN_W:0]           r2;
    logic                     round_up;
    logic signed [NUM_W-1:0]  q_rnd;
    logic signed [NUM_W:0]    v;

    assign out_free = !out_valid_reg || out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (!q_stat.empty) state_next = ST_MUL;
            ST_MUL:  state_next = req_reg.flat ? ST_DONE : ST_ABS;
            ST_ABS:  state_next = ST_DIV;
            ST_DIV:  if (cnt_reg == '0) state_next = ST_FIX;
            ST_FIX:  state_next = ST_RND;
            ST_RND:  state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        q_pop    = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE: q_pop    = !q_stat.empty;
            ST_DONE: out_load = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // One restoring divide step
    assign rem_sh = {rem_reg, dq_reg[MAG_W-1]};
    assign den_x  = {1'b0, req_reg.den};
    assign ge     = (rem_sh >= den_x);
    assign trial  = rem_sh - den_x;

    // Round half to even, add the low end, saturate
    assign r2       = {r_reg, 1'b0};
    assign round_up = (r2 > den_x) || ((r2 == den_x) && q_reg[0]);
    assign q_rnd    = q_reg + $signed({{(NUM_W-1){1'b0}}, round_up});
    assign v        = $signed({{(NUM_W+1-PIX_W){1'b0}}, req_reg.lo}) + (NUM_W+1)'(q_rnd);

    // Datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (q_pop)
                    req_reg <= q_rdata;
            end
            ST_MUL:
            begin
                num_reg  <= req_reg.diff * req_reg.span;
                res_pix  <= req_reg.lo;
                res_flat <= req_reg.flat;
            end
            ST_ABS:
            begin
                neg_reg <= num_reg[NUM_W-1];
                dq_reg  <= num_reg[NUM_W-1] ? MAG_W'(-num_reg) : MAG_W'(num_reg);
                rem_reg <= '0;
                cnt_reg <= CNT_W'(MAG_W - 1);
            end
            ST_DIV:
            begin
                rem_reg <= ge ? trial[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                dq_reg  <= {dq_reg[MAG_W-2:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
            end
            ST_FIX:
            begin
                // Turn the magnitude result into floor division
                if (!neg_reg)
                begin
                    q_reg <= $signed(dq_reg);
                    r_reg <= rem_reg;
                end
                else if (rem_reg == '0)
                begin
                    q_reg <= -$signed(dq_reg);
                    r_reg <= '0;
                end
                else
                begin
                    q_reg <= $signed(~dq_reg);
                    r_reg <= req_reg.den - rem_reg;
                end
            end
            ST_RND:
            begin
                if (v < 0)
                    res_pix <= '0;
                else if (v > PIX_MAX)
                    res_pix <= PIX_W'(PIX_MAX);
                else
                    res_pix <= v[PIX_W-1:0];
            end
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            pixel_out_reg <= res_pix;
            flat_reg      <= res_flat;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_out = pixel_out_reg;
    assign flat      = flat_reg;

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && cnt_reg != '0) |=>
            (state_reg == ST_DIV && cnt_reg == $past(cnt_reg) - 1'b1))
        else $error("divider step count broken");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIX) |-> (rem_reg < req_reg.den))
        else $error("divider remainder not below range");

    a_flat_low: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && res_flat) |-> (res_pix == req_reg.lo))
        else $error("flat frame result differs from low output");

endmodule
